// ===== hw/rtl/rue_pkg.sv =====
// ----------------------------------------------------------------------------
// rue_pkg: shared types and codes for the refresh URL extractor
// Command word passed from the classifier to the emitter, verdict codes.
// ----------------------------------------------------------------------------
package rue_pkg;

   // commands from front to back
   localparam logic [1:0] OP_STORE   = 2'd0;   // hold one blank in the store
   localparam logic [1:0] OP_EMIT    = 2'd1;   // send held blanks, then ch
   localparam logic [1:0] OP_VERDICT = 2'd2;   // send the closing verdict beat

   // verdict codes
   localparam logic [1:0] V_NONE = 2'd0;
   localparam logic [1:0] V_SELF = 2'd1;
   localparam logic [1:0] V_URL  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
      logic [1:0] verdict;
      logic       ovf;
   } cmd_type;

endpackage

// ===== hw/rtl/rue_front.sv =====
// ----------------------------------------------------------------------------
// rue_front: content string classifier
// Walks the time / url= grammar a byte a cycle unless q_full; issues commands.
// ----------------------------------------------------------------------------
module rue_front #(
   parameter int PENDING_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              q_full,
   output logic              q_push,
   output rue_pkg::cmd_type  q_cmd
);

   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

   localparam logic [3:0] PH_LEAD     = 4'd0;
   localparam logic [3:0] PH_TIME     = 4'd1;
   localparam logic [3:0] PH_SEP      = 4'd2;
   localparam logic [3:0] PH_GOT_U    = 4'd3;
   localparam logic [3:0] PH_GOT_R    = 4'd4;
   localparam logic [3:0] PH_PRE_EQ   = 4'd5;
   localparam logic [3:0] PH_AFTER_EQ = 4'd6;
   localparam logic [3:0] PH_AFTER_Q  = 4'd7;
   localparam logic [3:0] PH_URL      = 4'd8;
   localparam logic [3:0] PH_WAIT     = 4'd9;

   logic [3:0]       phase_ff, phase_in;
   logic             quoted_ff, quoted_in;
   logic [1:0]       decided_ff, decided_in;
   logic             started_ff, started_in;
   logic [CNT_W-1:0] pcount_ff, pcount_in;
   logic             dropped_ff, dropped_in;
   logic             ovf_ff, ovf_in;

   logic       fire;
   logic [7:0] c;
   logic       blank, wspace, timech, semi, quote;
   logic [1:0] end_v;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;
   assign c          = req_tdata;

   assign blank  = (c == 8'd32) || (c == 8'd9) || (c == 8'd10);
   assign wspace = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   assign timech = ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2e);
   assign semi   = (c == 8'h3b);
   assign quote  = (c == 8'h27);

   always_comb begin
      case (phase_ff)
         PH_LEAD:  end_v = rue_pkg::V_NONE;
         PH_URL:   end_v = started_ff ? rue_pkg::V_URL : rue_pkg::V_SELF;
         PH_TIME, PH_SEP, PH_GOT_U, PH_GOT_R, PH_PRE_EQ, PH_AFTER_EQ, PH_AFTER_Q: begin
            end_v = rue_pkg::V_SELF;
         end
         default:  end_v = decided_ff;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      quoted_in  = quoted_ff;
      decided_in = decided_ff;
      started_in = started_ff;
      pcount_in  = pcount_ff;
      dropped_in = dropped_ff;
      ovf_in     = ovf_ff;
      q_push          = 1'b0;
      q_cmd.op        = rue_pkg::OP_EMIT;
      q_cmd.ch        = c;
      q_cmd.verdict   = rue_pkg::V_NONE;
      q_cmd.ovf       = 1'b0;

      if (fire && req_tlast) begin
         q_push        = 1'b1;
         q_cmd.op      = rue_pkg::OP_VERDICT;
         q_cmd.ch      = 8'd0;
         q_cmd.verdict = end_v;
         q_cmd.ovf     = ovf_ff;
         phase_in   = PH_LEAD;
         quoted_in  = 1'b0;
         decided_in = rue_pkg::V_NONE;
         started_in = 1'b0;
         pcount_in  = '0;
         dropped_in = 1'b0;
         ovf_in     = 1'b0;
      end else if (fire) begin
         case (phase_ff)
            PH_LEAD: begin
               if (timech) begin
                  phase_in = PH_TIME;
               end else if (!blank) begin
                  decided_in = rue_pkg::V_NONE;
                  phase_in   = PH_WAIT;
               end
            end
            PH_TIME: begin
               if (blank || semi) begin
                  phase_in = PH_SEP;
               end else if (!timech) begin
                  decided_in = rue_pkg::V_SELF;
                  phase_in   = PH_WAIT;
               end
            end
            PH_SEP: begin
               if (c == 8'h75 || c == 8'h55) begin
                  phase_in = PH_GOT_U;
               end else if (!(blank || semi)) begin
                  decided_in = rue_pkg::V_SELF;
                  phase_in   = PH_WAIT;
               end
            end
            PH_GOT_U: begin
               if (c == 8'h72 || c == 8'h52) begin
                  phase_in = PH_GOT_R;
               end else begin
                  decided_in = rue_pkg::V_SELF;
                  phase_in   = PH_WAIT;
               end
            end
            PH_GOT_R: begin
               if (c == 8'h6c || c == 8'h4c) begin
                  phase_in = PH_PRE_EQ;
               end else begin
                  decided_in = rue_pkg::V_SELF;
                  phase_in   = PH_WAIT;
               end
            end
            PH_PRE_EQ: begin
               if (c == 8'h3d) begin
                  phase_in = PH_AFTER_EQ;
               end else if (!blank) begin
                  decided_in = rue_pkg::V_SELF;
                  phase_in   = PH_WAIT;
               end
            end
            PH_AFTER_EQ, PH_AFTER_Q: begin
               if (blank) begin
                  phase_in = phase_ff;
               end else if (quote) begin
                  if (phase_ff == PH_AFTER_EQ) begin
                     quoted_in = 1'b1;
                     phase_in  = PH_AFTER_Q;
                  end else begin
                     decided_in = rue_pkg::V_SELF;
                     phase_in   = PH_WAIT;
                  end
               end else begin
                  // first URL byte is always kept, even if it is whitespace
                  q_push     = 1'b1;
                  started_in = 1'b1;
                  phase_in   = PH_URL;
               end
            end
            PH_URL: begin
               if (quoted_ff && quote) begin
                  pcount_in  = '0;
                  dropped_in = 1'b0;
                  decided_in = started_ff ? rue_pkg::V_URL : rue_pkg::V_SELF;
                  phase_in   = PH_WAIT;
               end else if (wspace) begin
                  if (pcount_ff < CNT_W'(PENDING_DEPTH)) begin
                     q_push    = 1'b1;
                     q_cmd.op  = rue_pkg::OP_STORE;
                     pcount_in = pcount_ff + CNT_W'(1);
                  end else begin
                     dropped_in = 1'b1;
                  end
               end else begin
                  q_push = 1'b1;
                  if (dropped_ff) begin
                     ovf_in = 1'b1;
                  end
                  pcount_in  = '0;
                  dropped_in = 1'b0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         quoted_ff  <= 1'b0;
         decided_ff <= rue_pkg::V_NONE;
         started_ff <= 1'b0;
         pcount_ff  <= '0;
         dropped_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         quoted_ff  <= quoted_in;
         decided_ff <= decided_in;
         started_ff <= started_in;
         pcount_ff  <= pcount_in;
         dropped_ff <= dropped_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

// ===== hw/rtl/rue_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// rue_cmd_queue: two-entry command queue
// Decouples the classifier from the emitter so each may stall on its own.
// ----------------------------------------------------------------------------
module rue_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rue_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output rue_pkg::cmd_type  head_cmd
);

   rue_pkg::cmd_type entry_ff [rue_pkg::QUEUE_DEPTH];

   logic [rue_pkg::QUEUE_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rue_pkg::QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full       = (cnt_ff == rue_pkg::QUEUE_CNT_W'(rue_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = entry_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + rue_pkg::QUEUE_PTR_W'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + rue_pkg::QUEUE_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + rue_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - rue_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/rue_back.sv =====
// ----------------------------------------------------------------------------
// rue_back: blank store and result emitter
// Holds interior blanks, replays them before the next URL byte, drives rsp.
// ----------------------------------------------------------------------------
module rue_back #(
   parameter int PENDING_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  rue_pkg::cmd_type  head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;
   localparam logic [1:0] ST_TAIL = 2'd3;

   logic [7:0] store [PENDING_DEPTH];

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]       rd_ch_ff;
   logic             wr_en, rd_en;

   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] och_ff, och_in;
   logic [1:0] verdict_ff, verdict_in;
   logic       ovf_ff, ovf_in;
   logic       last_ff, last_in;
   logic       slot_free;

   assign slot_free  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {5'd0, ovf_ff, verdict_ff, och_ff};

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      pop        = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      valid_in   = valid_ff && !rsp_tready;
      kind_in    = kind_ff;
      och_in     = och_ff;
      verdict_in = verdict_ff;
      ovf_in     = ovf_ff;
      last_in    = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               case (head_cmd.op)
                  rue_pkg::OP_STORE: begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                     pop    = 1'b1;
                  end
                  rue_pkg::OP_EMIT, rue_pkg::OP_VERDICT: begin
                     if (head_cmd.op == rue_pkg::OP_EMIT && cnt_ff != '0) begin
                        idx_in   = '0;
                        state_in = ST_READ;
                     end else if (slot_free) begin
                        state_in = ST_TAIL;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) begin
               valid_in   = 1'b1;
               kind_in    = 1'b0;
               och_in     = rd_ch_ff;
               verdict_in = rue_pkg::V_NONE;
               ovf_in     = 1'b0;
               last_in    = 1'b0;
               state_in   = (idx_ff == cnt_ff) ? ST_TAIL : ST_READ;
            end
         end
         default: begin
            state_in = ST_TAIL;
         end
      endcase

      // closing beat of a command: URL byte or verdict, both clear the store
      if (head_valid && slot_free && (head_cmd.op != rue_pkg::OP_STORE) &&
          ((state_ff == ST_TAIL) ||
           (state_ff == ST_IDLE && (head_cmd.op == rue_pkg::OP_VERDICT || cnt_ff == '0)))) begin
         valid_in = 1'b1;
         last_in  = 1'b1;
         cnt_in   = '0;
         pop      = 1'b1;
         state_in = ST_IDLE;
         if (head_cmd.op == rue_pkg::OP_VERDICT) begin
            kind_in    = 1'b1;
            och_in     = 8'd0;
            verdict_in = head_cmd.verdict;
            ovf_in     = head_cmd.ovf;
         end else begin
            kind_in    = 1'b0;
            och_in     = head_cmd.ch;
            verdict_in = rue_pkg::V_NONE;
            ovf_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      och_ff     <= och_in;
      verdict_ff <= verdict_in;
      ovf_ff     <= ovf_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[cnt_ff[IDX_W-1:0]] <= head_cmd.ch;
      end
      if (rd_en) begin
         rd_ch_ff <= store[idx_ff[IDX_W-1:0]];
      end
   end

endmodule

// ===== hw/rtl/refresh_url_extractor.sv =====
// Path: a result beat is held in the command queue, then in the output register.
// Throughput: one input beat per cycle while the command queue is not full; a URL byte
//   preceded by held blanks takes the emitter a start step, one store read plus one
//   send per blank, then the byte itself. The queue between classifier and emitter
//   absorbs such bursts up to two commands.
// Reset: synchronous, active high; parser returns to the leading-blank phase,
//   the blank store is emptied by clearing its count, no clearing pass.
// ----------------------------------------------------------------------------
// refresh_url_extractor: meta refresh content URL extractor
// Parses a refresh content string byte by byte, streams out the URL with
// trailing whitespace trimmed, and closes each string with a verdict beat.
// ----------------------------------------------------------------------------
module refresh_url_extractor #(
   parameter int PENDING_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_mark: closes the string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_ch, [9:8] verdict, [10] blank_overflow
   output logic        rsp_tuser,   // kind: 0 URL byte, 1 verdict beat
   output logic        rsp_tlast    // last beat caused by the input beat
);

   // front: grammar walk and classification of each beat
   // back:  blank store, replay of held blanks, output register
   logic             q_full, q_push, q_pop, q_valid;
   rue_pkg::cmd_type q_cmd, q_head;

   rue_front #(
      .PENDING_DEPTH(PENDING_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   rue_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   rue_back #(
      .PENDING_DEPTH(PENDING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_cmd   (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
